FILE: src/lgrs_pkg.sv
// Shared types and constants for the Life row stencil.
`default_nettype none

package lgrs_pkg;

    // Field widths fixed by the interface
    localparam int ROW_W = 64;
    localparam int CFG_W = 7;

    // Neighbor counts for B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Result queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    // Results pushed by one input transaction
    typedef struct packed {
        logic first;   // next generation of the row held before this one
        logic second;  // next generation of the final row itself
    } lgrs_push_t;

endpackage

`default_nettype wire

FILE: src/lgrs_lane.sv
// One cell of the Life rule: neighbor count and birth/survival decision.
`default_nettype none

module lgrs_lane (
    input  wire logic [2:0] above,
    input  wire logic [2:0] middle,
    input  wire logic [2:0] below,
    output logic            alive
);

    logic [3:0] count;

    always_comb
    begin
        count = 4'd0;
        for (int d = 0; d < 3; d++)
        begin
            count = count + 4'(above[d]) + 4'(below[d]);
        end
        count = count + 4'(middle[0]) + 4'(middle[2]);
        alive = (count == lgrs_pkg::BIRTH_COUNT)
             || ((count == lgrs_pkg::SURVIVE_COUNT) && middle[1]);
    end

endmodule

`default_nettype wire

FILE: src/lgrs_row_stencil.sv
// A row of Life lanes plus the merge into one masked result row.
`default_nettype none

module lgrs_row_stencil #(
    parameter int CELLS = 64
) (
    input  wire logic [CELLS-1:0] above,
    input  wire logic [CELLS-1:0] middle,
    input  wire logic [CELLS-1:0] below,
    input  wire logic [CELLS-1:0] live_mask,
    output logic      [CELLS-1:0] next_row
);

    // Dead border on both sides, no wrap
    logic [CELLS+1:0] above_pad;
    logic [CELLS+1:0] middle_pad;
    logic [CELLS+1:0] below_pad;
    logic [CELLS-1:0] lane_alive;

    assign above_pad  = {1'b0, above  & live_mask, 1'b0};
    assign middle_pad = {1'b0, middle & live_mask, 1'b0};
    assign below_pad  = {1'b0, below  & live_mask, 1'b0};

    for (genvar i = 0; i < CELLS; i++)
    begin : g_lane
        lgrs_lane u_lane (
            .above  (above_pad[i+2:i]),
            .middle (middle_pad[i+2:i]),
            .below  (below_pad[i+2:i]),
            .alive  (lane_alive[i])
        );
    end

    assign next_row = lane_alive & live_mask;

endmodule

`default_nettype wire

FILE: src/lgrs_out_queue.sv
// Small result queue: up to two pushes and one pop per cycle.
`default_nettype none

module lgrs_out_queue #(
    parameter int WIDTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lgrs_pkg::lgrs_push_t     push,
    input  wire logic [WIDTH-1:0]         data_first,
    input  wire logic [WIDTH-1:0]         data_second,
    output logic                          room,
    output logic                          head_valid,
    input  wire logic                     head_ready,
    output logic      [WIDTH-1:0]         head_data
);

    localparam int DEPTH = lgrs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] second_idx;
    logic             pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    // Second result lands behind the first when both are pushed
    assign second_idx = wr_ptr_reg + PTR_W'(push.first);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.first) + PTR_W'(push.second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.first) + CNT_W'(push.second)
                    - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[wr_ptr_reg] <= data_first;
        end
        if (push.second)
        begin
            entry_reg[second_idx] <= data_second;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.first || push.second) |-> room)
        else $error("push into result queue without room");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

FILE: src/life_generation_row_stencil.sv
// Top level: one Life generation over a raster frame, one row per transaction.
//
//  channel   signals                          direction  meaning
//  input     in_valid/in_ready, row_bits,     in         one current-generation row
//            final_row
//  output    out_valid/out_ready, next_row,   out        one next-generation row
//            frame_end
//  config    cfg_we, cfg_wdata                in         row_cells, no wait
//
// One row transaction per cycle while in_ready is high; all MAX_CELLS lanes evaluate
// a row in the same cycle. A final row yields two results, popped one at a time; a
// four-entry result queue absorbs that and keeps taking rows while results wait.
// in_ready drops only when the queue lacks room for two results.
// Reset empties the queue, clears the held rows and sets the width to MAX_CELLS.
`default_nettype none

module life_generation_row_stencil #(
    parameter int MAX_CELLS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lgrs_pkg::ROW_W-1:0]    row_bits,
    input  wire logic                          final_row,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lgrs_pkg::ROW_W-1:0]    next_row,
    output logic                               frame_end,
    input  wire logic                          cfg_we,
    input  wire logic [lgrs_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int RowW   = lgrs_pkg::ROW_W;
    localparam int CfgW   = lgrs_pkg::CFG_W;
    localparam int EntryW = MAX_CELLS + 1;

    logic [MAX_CELLS-1:0] upper_reg, upper_next;
    logic [MAX_CELLS-1:0] middle_reg, middle_next;
    logic                 held_reg, held_next;
    logic [MAX_CELLS-1:0] live_mask_reg, live_mask_next;

    logic                 accept;
    logic [MAX_CELLS-1:0] row_live;
    logic [MAX_CELLS-1:0] upper_for_final;
    logic [MAX_CELLS-1:0] gen_first;
    logic [MAX_CELLS-1:0] gen_second;
    lgrs_pkg::lgrs_push_t push;
    logic [EntryW-1:0]    head_data;

    assign accept          = in_valid && in_ready;
    assign row_live        = row_bits[MAX_CELLS-1:0] & live_mask_reg;
    assign upper_for_final = held_reg ? middle_reg : '0;

    // Row above the incoming one
    lgrs_row_stencil #(.CELLS(MAX_CELLS)) u_stencil_first (
        .above     (upper_reg),
        .middle    (middle_reg),
        .below     (row_live),
        .live_mask (live_mask_reg),
        .next_row  (gen_first)
    );

    // Final row, dead row below it
    lgrs_row_stencil #(.CELLS(MAX_CELLS)) u_stencil_second (
        .above     (upper_for_final),
        .middle    (row_live),
        .below     ('0),
        .live_mask (live_mask_reg),
        .next_row  (gen_second)
    );

    always_comb
    begin
        push.first  = accept && held_reg;
        push.second = accept && final_row;
    end

    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        held_next   = held_reg;
        if (accept)
        begin
            if (final_row)
            begin
                upper_next  = '0;
                middle_next = '0;
                held_next   = 1'b0;
            end
            else
            begin
                upper_next  = upper_for_final;
                middle_next = row_live;
                held_next   = 1'b1;
            end
        end
    end

    // Widths above MAX_CELLS saturate since only MAX_CELLS lanes exist
    always_comb
    begin
        live_mask_next = live_mask_reg;
        if (cfg_we)
        begin
            for (int i = 0; i < MAX_CELLS; i++)
            begin
                live_mask_next[i] = (cfg_wdata > CfgW'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg     <= '0;
            middle_reg    <= '0;
            held_reg      <= 1'b0;
            live_mask_reg <= '1;
        end
        else
        begin
            upper_reg     <= upper_next;
            middle_reg    <= middle_next;
            held_reg      <= held_next;
            live_mask_reg <= live_mask_next;
        end
    end

    lgrs_out_queue #(.WIDTH(EntryW)) u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_first  ({1'b0, gen_first}),
        .data_second ({1'b1, gen_second}),
        .room        (in_ready),
        .head_valid  (out_valid),
        .head_ready  (out_ready),
        .head_data   (head_data)
    );

    assign next_row  = RowW'(head_data[MAX_CELLS-1:0]);
    assign frame_end = head_data[MAX_CELLS];

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_row) |=> (!held_reg && upper_reg == '0 && middle_reg == '0))
        else $error("final row did not clear held rows");

    a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !final_row) |=> held_reg)
        else $error("accepted row not held");

    a_first_row_top: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> (upper_reg == '0 && middle_reg == '0))
        else $error("rows present while nothing held");

endmodule

`default_nettype wire
